>>> sv/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg: shared types and constants for the SHA-256 stream hasher
// Holds the round constants, the initial chaining words, the sequencer state
// type and the SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned BLOCK_WORDS  = 16;
  localparam int unsigned ROUND_COUNT  = 64;
  localparam int unsigned DIGEST_WORDS = 8;

  localparam int unsigned FILL_W  = $clog2(BLOCK_WORDS);
  localparam int unsigned ROUND_W = $clog2(ROUND_COUNT);
  localparam int unsigned INDEX_W = $clog2(DIGEST_WORDS);

  // Last digest index, flags the final beat
  localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(DIGEST_WORDS - 1);

  // Padding marker byte in the top lane of a word
  localparam logic [31:0] PAD_WORD = 32'h8000_0000;

  localparam logic [31:0] ROUND_K [ROUND_COUNT] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_ADD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

>>> sv/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher: streaming SHA-256 over 32-bit big-endian words
// One round unit is reused for all 64 rounds of each block under a small
// sequencer; padding and length words are pushed by the same sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one message word per beat, first byte in bits
//   31:24. in_byte_count gives the valid leading bytes of the last word
//   (values above four act as four); other words always carry four bytes.
//   in_last_word ends the message.
//   Result channel (out_*): eight beats per message, H0 to H7 in order,
//   out_digest_done high on the beat of H7.
//   Timing: a word that does not complete a block leaves the sequencer idle.
//   The word that fills a block starts the round unit, one round per cycle,
//   then a fold into the chaining words; in_stall stays high through the
//   rounds and the fold, so no new word is taken while a block is compressed.
//   After the last word the sequencer pushes padding and the length one
//   word per cycle, pausing while a full block runs its rounds (up to 18
//   words, one or two blocks), then shows the digest.
//   While the receiver stalls, the current digest beat holds; no new input
//   is taken until all eight beats have gone.
//   Reset (rst_n low, synchronous) loads the initial chaining words and
//   clears the length, fill count and sequencer.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_digest_index,
  output logic        out_digest_done
);

  state_t               state_r, state_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [ROUND_W-1:0]   rnd_r, rnd_nxt;
  logic [63:0]          bitlen_r, bitlen_nxt;
  logic                 pad80_r, pad80_nxt;
  logic                 finish_r, finish_nxt;
  logic                 hi_sent_r, hi_sent_nxt;
  logic                 len_done_r, len_done_nxt;
  logic [INDEX_W-1:0]   idx_r, idx_nxt;
  logic [31:0]          chain_r [DIGEST_WORDS];
  logic [31:0]          chain_nxt [DIGEST_WORDS];
  logic [31:0]          work_r [DIGEST_WORDS];
  logic [31:0]          work_nxt [DIGEST_WORDS];
  logic [31:0]          sched_r [BLOCK_WORDS];
  logic [31:0]          sched_nxt [BLOCK_WORDS];

  logic                 in_acc;
  logic                 out_acc;
  logic                 push_en;
  logic [31:0]          push_data;
  logic                 block_full;
  logic                 shift_en;
  logic [31:0]          shift_in;
  logic [2:0]           cnt_clamp;
  logic [31:0]          keep_mask;
  logic [31:0]          mark_bits;
  logic [31:0]          last_data;
  logic [31:0]          t1;
  logic [31:0]          t2;
  logic [31:0]          sched_new;
  logic [31:0]          ch_val;
  logic [31:0]          maj_val;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Handshake and result ports
  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_digest_word  = chain_r[idx_r];
  assign out_digest_index = idx_r;
  assign out_digest_done  = (idx_r == LAST_INDEX);

  // Mask and mark the final word
  always_comb begin
    cnt_clamp = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
    unique case (cnt_clamp)
      3'd0: begin
        keep_mask = 32'h0000_0000;
        mark_bits = 32'h8000_0000;
      end
      3'd1: begin
        keep_mask = 32'hff00_0000;
        mark_bits = 32'h0080_0000;
      end
      3'd2: begin
        keep_mask = 32'hffff_0000;
        mark_bits = 32'h0000_8000;
      end
      3'd3: begin
        keep_mask = 32'hffff_ff00;
        mark_bits = 32'h0000_0080;
      end
      default: begin
        keep_mask = 32'hffff_ffff;
        mark_bits = 32'h0000_0000;
      end
    endcase
    last_data = (in_message_word & keep_mask) | mark_bits;
  end

  // Round unit and schedule expansion
  always_comb begin
    ch_val    = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
    maj_val   = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^
                (work_r[1] & work_r[2]);
    t1        = work_r[7] + ROUND_K[rnd_r] + sched_r[0] + big_sigma1(work_r[4]) + ch_val;
    t2        = big_sigma0(work_r[0]) + maj_val;
    sched_new = small_sigma1(sched_r[14]) + sched_r[9] + small_sigma0(sched_r[1]) +
                sched_r[0];
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    rnd_nxt      = rnd_r;
    bitlen_nxt   = bitlen_r;
    pad80_nxt    = pad80_r;
    finish_nxt   = finish_r;
    hi_sent_nxt  = hi_sent_r;
    len_done_nxt = len_done_r;
    idx_nxt      = idx_r;
    chain_nxt    = chain_r;
    work_nxt     = work_r;
    push_en      = 1'b0;
    push_data    = 32'h0;
    shift_en     = 1'b0;
    shift_in     = 32'h0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          push_en = 1'b1;
          if (in_last_word) begin
            push_data  = last_data;
            bitlen_nxt = bitlen_r + {58'b0, cnt_clamp, 3'b000};
            pad80_nxt  = (cnt_clamp == 3'd4);
            finish_nxt = 1'b1;
          end else begin
            push_data  = in_message_word;
            bitlen_nxt = bitlen_r + 64'd32;
          end
        end
      end
      S_PAD: begin
        push_en = 1'b1;
        priority if (pad80_r) begin
          push_data = PAD_WORD;
          pad80_nxt = 1'b0;
        end else if (fill_r == FILL_W'(BLOCK_WORDS - 2)) begin
          push_data   = bitlen_r[63:32];
          hi_sent_nxt = 1'b1;
        end else if (fill_r == FILL_W'(BLOCK_WORDS - 1) && hi_sent_r) begin
          push_data    = bitlen_r[31:0];
          len_done_nxt = 1'b1;
        end else begin
          push_data = 32'h0;
        end
      end
      S_ROUND: begin
        shift_en = 1'b1;
        shift_in = sched_new;
        for (int i = DIGEST_WORDS - 1; i > 0; i--) begin
          work_nxt[i] = work_r[i-1];
        end
        work_nxt[4] = work_r[3] + t1;
        work_nxt[0] = t1 + t2;
        rnd_nxt     = rnd_r + ROUND_W'(1);
        if (rnd_r == ROUND_W'(ROUND_COUNT - 1)) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
          chain_nxt[i] = chain_r[i] + work_r[i];
        end
        priority if (len_done_r) begin
          state_nxt = S_OUT;
        end else if (finish_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + INDEX_W'(1);
          if (idx_r == LAST_INDEX) begin
            chain_nxt    = INIT_H;
            bitlen_nxt   = 64'h0;
            finish_nxt   = 1'b0;
            hi_sent_nxt  = 1'b0;
            len_done_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Push a word into the block; a full block starts the rounds
    block_full = push_en && (fill_r == FILL_W'(BLOCK_WORDS - 1));
    if (push_en) begin
      shift_en = 1'b1;
      shift_in = push_data;
      fill_nxt = fill_r + FILL_W'(1);
      if (block_full) begin
        work_nxt  = chain_r;
        rnd_nxt   = '0;
        state_nxt = S_ROUND;
      end else if (state_r == S_IDLE && in_last_word) begin
        state_nxt = S_PAD;
      end
    end

    // Advance the schedule window
    sched_nxt = sched_r;
    if (shift_en) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        sched_nxt[i] = sched_r[i+1];
      end
      sched_nxt[BLOCK_WORDS-1] = shift_in;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      rnd_r      <= '0;
      bitlen_r   <= 64'h0;
      pad80_r    <= 1'b0;
      finish_r   <= 1'b0;
      hi_sent_r  <= 1'b0;
      len_done_r <= 1'b0;
      idx_r      <= '0;
      chain_r    <= INIT_H;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      rnd_r      <= rnd_nxt;
      bitlen_r   <= bitlen_nxt;
      pad80_r    <= pad80_nxt;
      finish_r   <= finish_nxt;
      hi_sent_r  <= hi_sent_nxt;
      len_done_r <= len_done_nxt;
      idx_r      <= idx_nxt;
      chain_r    <= chain_nxt;
    end
  end

  // Working variables and schedule window, no reset
  always_ff @(posedge clk) begin
    work_r  <= work_nxt;
    sched_r <= sched_nxt;
  end

endmodule

>>> sv/sha256_checker.sv
// ----------------------------------------------------------------------------
// sha256_checker: port-level checks for the SHA-256 stream hasher
// Watches the handshakes and the digest beat order; bound to the top level.
// ----------------------------------------------------------------------------
module sha256_checker
  import sha256_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_digest_index,
  input logic        out_digest_done
);

  // Hold a stalled digest beat
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word) &&
      $stable(out_digest_index))
    else $error("stalled digest beat changed");

  // Flag only the final digest word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digest_done == (out_digest_index == LAST_INDEX)))
    else $error("digest_done does not match index");

  // Advance the index beat by beat within one digest
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_digest_done |=>
      out_valid && (out_digest_index == $past(out_digest_index) + 3'd1))
    else $error("digest beats out of order");

  // Take no input while a digest is shown
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during digest output");

  // Start each digest at index zero
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_digest_index == 3'd0))
    else $error("digest did not start at H0");

endmodule

bind sha256_stream_hasher sha256_checker u_sha256_checker (.*);

>>> tb/sha256_digest_board_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_digest_board_pkg: digest predictor and scoreboard for the hasher
// Rebuilds SHA-256 padding and compression from each accepted input beat,
// queues the eight digest beats that a last word produces, and compares the
// result beats of the block against them in order.
// ----------------------------------------------------------------------------
package sha256_digest_board_pkg;

  import sha256_pkg::*;

  // Round constants, kept apart from the design's own table
  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_START [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Block slot where the 64-bit length begins
  localparam int unsigned LEN_SLOT   = 14;
  localparam logic [31:0] MARK_WORD  = 32'h8000_0000;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        done;
  } digest_beat_t;

  class sha256_digest_board;
    logic [31:0]  chain [8];
    logic [31:0]  blk [16];
    int unsigned  fill;
    logic [63:0]  bit_len;
    digest_beat_t digest_due [$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    // Return to the state of a fresh message
    function void restart();
      chain   = H_START;
      fill    = 0;
      bit_len = '0;
    endfunction

    static function logic [31:0] rotr(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // Run the 64 rounds on the held block and fold into the chain
    function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1;
      logic [31:0] t2;
      for (int t = 0; t < 16; t++) w[t] = blk[t];
      for (int t = 16; t < 64; t++) begin
        w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
               (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      end
      v = chain;
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[t];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        for (int i = 7; i > 0; i--) v[i] = v[i-1];
        v[4] = v[4] + t1;
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    function void absorb(logic [31:0] w_in);
      blk[fill] = w_in;
      fill++;
      if (fill == 16) begin
        fill = 0;
        compress();
      end
    endfunction

    // Account for one accepted input beat
    function void note_word(logic [31:0] word, logic [2:0] count, logic last);
      int unsigned  nbytes;
      logic [31:0]  keep;
      digest_beat_t beat;
      if (!last) begin
        bit_len = bit_len + 64'd32;
        absorb(word);
        return;
      end
      nbytes  = (count > 4) ? 4 : count;
      bit_len = bit_len + 64'(nbytes * 8);
      // Marker byte follows the valid bytes, or opens a word of its own
      if (nbytes == 4) begin
        absorb(word);
        absorb(MARK_WORD);
      end else begin
        keep = ~(32'hffff_ffff >> (8 * nbytes));
        absorb((word & keep) | (MARK_WORD >> (8 * nbytes)));
      end
      while (fill != LEN_SLOT) absorb('0);
      absorb(bit_len[63:32]);
      absorb(bit_len[31:0]);
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        beat.word  = chain[i];
        beat.index = 3'(i);
        beat.done  = (beat.index == LAST_INDEX);
        digest_due.push_back(beat);
      end
      restart();
    endfunction

    // Compare one result beat with the oldest queued digest beat
    function void check_digest(logic [31:0] word, logic [2:0] index, logic done);
      digest_beat_t want;
      if (digest_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected digest beat: word %h index %0d done %0d", word, index, done);
        return;
      end
      want = digest_due.pop_front();
      if (want.word !== word || want.index !== index || want.done !== done) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("digest beat H%0d: expected %h/%0d/%0d, got %h/%0d/%0d",
                   want.index, want.word, want.index, want.done, word, index, done);
      end
    endfunction

    function int unsigned pending();
      return digest_due.size();
    endfunction
  endclass

endpackage

>>> tb/sha256_stream_hasher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_test: self-checking bench for the SHA-256 hasher
// Sends directed messages for every byte count and for a tail that forces an
// extra padding block, then random messages under several idle and stall mixes, including a long
// receiver hold-off; each digest beat is checked against the predictor.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_test;

  import sha256_pkg::*;
  import sha256_digest_board_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned TAIL_CYCLES  = 200;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_ITEMS  = 33;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [31:0] in_message_word  = '0;
  logic [2:0]  in_byte_count    = '0;
  logic        in_last_word     = 1'b0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_digest_index;
  logic        out_digest_done;

  logic        hold_req         = 1'b0;
  logic        hold_used        = 1'b0;
  int unsigned hold_left        = 0;
  int unsigned stall_pct        = 0;
  int unsigned idle_pct         = 0;
  int unsigned words_sent       = 0;
  int unsigned cycle_count      = 0;

  sha256_digest_board board;

  sha256_stream_hasher i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_message_word  (in_message_word),
    .in_byte_count    (in_byte_count),
    .in_last_word     (in_last_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digest_word  (out_digest_word),
    .out_digest_index (out_digest_index),
    .out_digest_done  (out_digest_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sha256_stream_hasher: mismatch");
      $finish;
    end
  end

  // Count down a single long receiver hold-off once requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Check each accepted result beat, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_digest(out_digest_word, out_digest_index, out_digest_done);
    out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Offer one beat, wait for it to be taken, then record it
  task automatic push_beat(input logic [31:0] word, input logic [2:0] count,
                           input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_message_word <= word;
    in_byte_count   <= count;
    in_last_word    <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(word, count, last);
    words_sent++;
  endtask

  task automatic push_message(input int unsigned body_words, input logic [2:0] tail_count);
    for (int i = 0; i < body_words; i++)
      push_beat(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
    push_beat(pick_word(), tail_count, 1'b1);
  endtask

  // Hold the sender until every queued digest beat has come back
  task automatic drain_digests();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Random messages: mostly under one block, some spanning several
  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned items);
    int unsigned goal;
    int unsigned body;
    goal      = words_sent + items;
    idle_pct  = idle;
    stall_pct <= stall;
    while (words_sent < goal) begin
      body = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 15);
      push_message(body, 3'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every tail byte count, empty messages, ignored counts
    push_beat(32'hffff_ffff, 3'd0, 1'b1);
    push_beat(32'hffff_ffff, 3'd1, 1'b1);
    push_beat(32'h0000_0000, 3'd2, 1'b1);
    push_beat(32'hffff_ffff, 3'd3, 1'b1);
    push_beat(32'hffff_ffff, 3'd4, 1'b1);
    push_beat(32'h6162_6364, 3'd5, 1'b1);
    push_beat(32'h0123_4567, 3'd6, 1'b1);
    push_beat(32'h89ab_cdef, 3'd7, 1'b1);
    push_beat(32'h0000_0000, 3'd0, 1'b0);
    push_beat(32'hffff_ffff, 3'd0, 1'b1);
    push_beat(32'hffff_ffff, 3'd7, 1'b0);
    push_beat(32'h0000_0000, 3'd2, 1'b1);
    // Full tail word leaves no room for the length: extra block
    push_message(13, 3'd4);
    drain_digests();

    // Random phases; the first one also holds the receiver off for long
    hold_req <= 1'b1;
    run_phase(0, 0, PHASE_ITEMS);
    drain_digests();
    run_phase(51, 0, PHASE_ITEMS);
    drain_digests();
    run_phase(0, 51, PHASE_ITEMS);
    drain_digests();
    run_phase(9, 9, PHASE_ITEMS);

    drain_digests();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("sha256_stream_hasher: match");
    end else begin
      $display("sha256_stream_hasher: mismatch");
    end
    $finish;
  end

endmodule
